/* sv/hdr_tm_pkg.sv */
package hdr_tm_pkg;

	localparam int CH = 3;
	localparam int IN_W = 24;
	localparam int OUT_W = 12;
	localparam int EXP_W = 13;
	localparam int WP_W = 16;
	localparam int G_W = 31;
	localparam int E_W = 40;
	localparam int C_W = 29;
	localparam int T_W = 25;
	localparam int PV_W = 35;
	localparam int MA_W = 30;
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 42;
	localparam int DIV_Q_W = 30;
	localparam int GAIN_STAGES = 8;
	localparam int LOG_BITS = 16;
	localparam int NY_W = 18;
	localparam int K_LIN_W = 36;
	localparam int SETTLE_W = $clog2(GAIN_STAGES + 1);
	localparam int IN_TDATA_W = ((CH * IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((CH * OUT_W + 7) / 8) * 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;
	localparam logic [G_W-1:0] Q30_ONE = G_W'(64'd1 << 30);
	localparam logic [E_W-1:0] E_MAX = '1;
	localparam logic [T_W-1:0] T_ONE = T_W'(64'd1 << 24);
	localparam logic [C_W-1:0] C_MAX = C_W'(64'd1 << 28);
	localparam logic [K_LIN_W-1:0] K_LIN = K_LIN_W'(64'd846725 * 64'(OUT_MAX));
	localparam logic [T_W-1:0] LIN_LIMIT = T_W'(52526);
	localparam logic [25:0] ACES_A1 = 26'd42110730;
	localparam logic [MA_W-1:0] ACES_B1 = MA_W'(503316);
	localparam logic [25:0] ACES_A2 = 26'd40768532;
	localparam logic [MA_W-1:0] ACES_B2 = MA_W'(9898557);
	localparam logic [PV_W-1:0] ACES_D0 = PV_W'(2348810);
	localparam logic [16:0] SRGB_MUL = 17'd69140;
	localparam logic [31:0] SRGB_SUB = 32'd59055800;
	localparam logic [21:0] DIV3_MUL = 22'd2796203;
	localparam logic [WP_W-1:0] WP_RESET = WP_W'(256);

	localparam logic [G_W-1:0] POW2_TAB [LOG_BITS] = '{
		31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
		31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
		31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
		31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_EXPOSURE = 2'd0,
		CFG_TONE = 2'd1,
		CFG_WHITE = 2'd2
	} cfg_index_t;

	function automatic logic [G_W-1:0] mul_q30(input logic [G_W-1:0] a,
			input logic [G_W-1:0] b);
		logic [2*G_W-1:0] p;
		p = (2*G_W)'(a) * (2*G_W)'(b) + ((2*G_W)'(1) << 29);
		return G_W'(p >> 30);
	endfunction

endpackage

/* sv/hdr_tm_gain.sv */
module hdr_tm_gain (
	input  logic                              clk,
	input  logic [hdr_tm_pkg::GAIN_STAGES-1:0] frac,
	output logic [hdr_tm_pkg::G_W-1:0]         gain
);

	logic [hdr_tm_pkg::G_W-1:0] g_s [1:hdr_tm_pkg::GAIN_STAGES];

	for (genvar k = 1; k <= hdr_tm_pkg::GAIN_STAGES; k++) begin : g_stage
		logic [hdr_tm_pkg::G_W-1:0] prev;
		if (k == 1) begin : g_first
			assign prev = hdr_tm_pkg::Q30_ONE;
		end else begin : g_next
			assign prev = g_s[k-1];
		end
		always_ff @(posedge clk) begin
			g_s[k] <= frac[hdr_tm_pkg::GAIN_STAGES-k] ?
				hdr_tm_pkg::mul_q30(prev, hdr_tm_pkg::POW2_TAB[k-1]) : prev;
		end
	end

	assign gain = g_s[hdr_tm_pkg::GAIN_STAGES];

endmodule

/* sv/hdr_tm_div.sv */
module hdr_tm_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_in,
	input  logic [hdr_tm_pkg::DIV_NUM_W-1:0]    num,
	input  logic [hdr_tm_pkg::DIV_DEN_W-1:0]    den,
	output logic                                vld_out,
	output logic [hdr_tm_pkg::DIV_Q_W-1:0]      quo,
	output logic                                ovf
);

	logic                                 vld_s [0:hdr_tm_pkg::DIV_Q_W];
	logic                                 ovf_s [0:hdr_tm_pkg::DIV_Q_W];
	logic [hdr_tm_pkg::DIV_DEN_W-1:0]     rem_s [0:hdr_tm_pkg::DIV_Q_W];
	logic [hdr_tm_pkg::DIV_DEN_W-1:0]     den_s [0:hdr_tm_pkg::DIV_Q_W];
	logic [hdr_tm_pkg::DIV_Q_W-1:0]       low_s [0:hdr_tm_pkg::DIV_Q_W];
	logic [hdr_tm_pkg::DIV_Q_W-1:0]       quo_s [0:hdr_tm_pkg::DIV_Q_W];
	logic [hdr_tm_pkg::DIV_DEN_W-1:0]     num_hi;
	logic                                 hi_ge;

	// A quotient that does not fit the stages is flagged up front.
	assign num_hi = hdr_tm_pkg::DIV_DEN_W'(num[hdr_tm_pkg::DIV_NUM_W-1:hdr_tm_pkg::DIV_Q_W]);
	assign hi_ge = num_hi >= den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= hi_ge;
			rem_s[0] <= hi_ge ? '0 : num_hi;
			den_s[0] <= den;
			low_s[0] <= num[hdr_tm_pkg::DIV_Q_W-1:0];
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k <= hdr_tm_pkg::DIV_Q_W; k++) begin : d_stage
		logic [hdr_tm_pkg::DIV_DEN_W:0] trial;
		logic [hdr_tm_pkg::DIV_DEN_W:0] diff;
		logic                           ge;

		assign trial = {rem_s[k-1], low_s[k-1][hdr_tm_pkg::DIV_Q_W-1]};
		assign diff = trial - {1'b0, den_s[k-1]};
		assign ge = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ovf_s[k] <= ovf_s[k-1];
				rem_s[k] <= ge ? diff[hdr_tm_pkg::DIV_DEN_W-1:0] :
					trial[hdr_tm_pkg::DIV_DEN_W-1:0];
				den_s[k] <= den_s[k-1];
				low_s[k] <= low_s[k-1] << 1;
				quo_s[k] <= {quo_s[k-1][hdr_tm_pkg::DIV_Q_W-2:0], ge};
			end
		end
	end

	assign vld_out = vld_s[hdr_tm_pkg::DIV_Q_W];
	assign quo = quo_s[hdr_tm_pkg::DIV_Q_W];
	assign ovf = ovf_s[hdr_tm_pkg::DIV_Q_W];

endmodule

/* sv/hdr_tm_enc.sv */
module hdr_tm_enc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_in,
	input  logic [hdr_tm_pkg::T_W-1:0]      t,
	output logic                            vld_out,
	output logic [hdr_tm_pkg::OUT_W-1:0]    code
);

	localparam int NSQ = hdr_tm_pkg::LOG_BITS;
	localparam int GW = hdr_tm_pkg::G_W;
	localparam int OW = hdr_tm_pkg::OUT_W;

	// Squaring chain for the log.
	logic          vsq_s  [0:NSQ];
	logic [GW-1:0] man_s  [0:NSQ];
	logic [15:0]   frac_s [0:NSQ];
	logic [4:0]    pexp_s [0:NSQ];
	logic          lin_s  [0:NSQ];
	logic [OW-1:0] lcode_s[0:NSQ];

	// Power chain for the exponent.
	logic          vpw_s  [0:NSQ];
	logic [GW-1:0] g_s    [0:NSQ];
	logic [15:0]   u_s    [0:NSQ];
	logic          fz_s   [0:NSQ];
	logic [1:0]    k_s    [0:NSQ];
	logic          linp_s [0:NSQ];
	logic [OW-1:0] lcodep_s [0:NSQ];

	logic          v_p30_s, v_sv_s, v_out_s;
	logic [GW-1:0] p30_s;
	logic [31:0]   sv_s;
	logic          lin_p30_s, lin_sv_s;
	logic [OW-1:0] lcode_p30_s, lcode_sv_s, code_s;

	logic [4:0]    msb;
	logic [GW-1:0] man0;
	logic [51:0]   lprod;

	always_comb begin
		msb = '0;
		for (int i = 0; i < hdr_tm_pkg::T_W; i++) begin
			if (t[i]) begin
				msb = 5'(i);
			end
		end
	end

	assign man0 = GW'(GW'(t) << (5'd30 - msb));
	assign lprod = 52'(t[15:0]) * 52'(hdr_tm_pkg::K_LIN) + (52'd1 << 39);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsq_s[0] <= 1'b0;
		end else if (en) begin
			vsq_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			man_s[0] <= man0;
			frac_s[0] <= '0;
			pexp_s[0] <= 5'(5'd24 - msb);
			lin_s[0] <= t <= hdr_tm_pkg::LIN_LIMIT;
			lcode_s[0] <= OW'(lprod >> 40);
		end
	end

	for (genvar k = 1; k <= NSQ; k++) begin : sq_stage
		logic [2*GW-1:0] sq;
		logic [GW:0]     m2;

		assign sq = (2*GW)'(man_s[k-1]) * (2*GW)'(man_s[k-1]) + ((2*GW)'(1) << 29);
		assign m2 = (GW+1)'(sq >> 30);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vsq_s[k] <= 1'b0;
			end else if (en) begin
				vsq_s[k] <= vsq_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				man_s[k] <= m2[GW] ? m2[GW:1] : m2[GW-1:0];
				frac_s[k] <= {frac_s[k-1][14:0], m2[GW]};
				pexp_s[k] <= pexp_s[k-1];
				lin_s[k] <= lin_s[k-1];
				lcode_s[k] <= lcode_s[k-1];
			end
		end
	end

	// Scale the log by 5/12; the divide by 3 is a reciprocal multiply.
	localparam int NY_W_L = hdr_tm_pkg::NY_W;
	logic [19:0] nl;
	logic [22:0] v5;
	logic [42:0] d3;
	logic [NY_W_L-1:0] ny;

	assign nl = {pexp_s[NSQ][3:0], 16'd0} - {4'd0, frac_s[NSQ]};
	assign v5 = 23'(nl) * 23'd5 + 23'd6;
	assign d3 = 43'(v5[22:2]) * 43'(hdr_tm_pkg::DIV3_MUL);
	assign ny = NY_W_L'(d3 >> 23);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpw_s[0] <= 1'b0;
		end else if (en) begin
			vpw_s[0] <= vsq_s[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s[0] <= hdr_tm_pkg::Q30_ONE;
			u_s[0] <= 16'(17'h10000 - {1'b0, ny[15:0]});
			fz_s[0] <= ny[15:0] == 16'd0;
			k_s[0] <= ny[17:16];
			linp_s[0] <= lin_s[NSQ];
			lcodep_s[0] <= lcode_s[NSQ];
		end
	end

	for (genvar k = 1; k <= NSQ; k++) begin : pw_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vpw_s[k] <= 1'b0;
			end else if (en) begin
				vpw_s[k] <= vpw_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				g_s[k] <= u_s[k-1][NSQ-k] ?
					hdr_tm_pkg::mul_q30(g_s[k-1], hdr_tm_pkg::POW2_TAB[k-1]) : g_s[k-1];
				u_s[k] <= u_s[k-1];
				fz_s[k] <= fz_s[k-1];
				k_s[k] <= k_s[k-1];
				linp_s[k] <= linp_s[k-1];
				lcodep_s[k] <= lcodep_s[k-1];
			end
		end
	end

	logic [47:0]    svp;
	logic [31:0]    sv;
	logic [31+OW:0] rp;
	logic [OW+1:0]  r;

	assign svp = 48'(p30_s) * 48'(hdr_tm_pkg::SRGB_MUL) + (48'd1 << 15);
	assign sv = (32'(svp >> 16) > hdr_tm_pkg::SRGB_SUB) ?
		32'(svp >> 16) - hdr_tm_pkg::SRGB_SUB : 32'd0;
	assign rp = (32+OW)'(sv_s) * (32+OW)'(hdr_tm_pkg::OUT_MAX) + ((32+OW)'(1) << 29);
	assign r = (OW+2)'(rp >> 30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p30_s <= 1'b0;
			v_sv_s <= 1'b0;
			v_out_s <= 1'b0;
		end else if (en) begin
			v_p30_s <= vpw_s[NSQ];
			v_sv_s <= v_p30_s;
			v_out_s <= v_sv_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p30_s <= fz_s[NSQ] ? (hdr_tm_pkg::Q30_ONE >> k_s[NSQ]) :
				(g_s[NSQ] >> ({1'b0, k_s[NSQ]} + 3'd1));
			lin_p30_s <= linp_s[NSQ];
			lcode_p30_s <= lcodep_s[NSQ];
			sv_s <= sv;
			lin_sv_s <= lin_p30_s;
			lcode_sv_s <= lcode_p30_s;
			if (lin_sv_s) begin
				code_s <= lcode_sv_s;
			end else begin
				code_s <= (r > (OW+2)'(hdr_tm_pkg::OUT_MAX)) ? hdr_tm_pkg::OUT_MAX : OW'(r);
			end
		end
	end

	assign vld_out = v_out_s;
	assign code = code_s;

endmodule

/* sv/hdr_tm_lane.sv */
module hdr_tm_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_in,
	input  logic [hdr_tm_pkg::IN_W-1:0]     x,
	input  logic [hdr_tm_pkg::G_W-1:0]      gain,
	input  logic [4:0]                      exp_int,
	input  logic                            tone_curve,
	input  logic [hdr_tm_pkg::WP_W-1:0]     white_point,
	output logic                            vld_out,
	output logic [hdr_tm_pkg::OUT_W-1:0]    code
);

	localparam int PW = hdr_tm_pkg::IN_W + hdr_tm_pkg::G_W;
	localparam int NW = hdr_tm_pkg::DIV_NUM_W;
	localparam int DW = hdr_tm_pkg::DIV_DEN_W;

	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [PW-1:0]             prod_s1;
	logic [hdr_tm_pkg::E_W-1:0] e_s2;
	logic [hdr_tm_pkg::C_W-1:0] c_s3, c_s4, c_s5;
	logic [hdr_tm_pkg::MA_W-1:0] ma_s4, mb_s4;
	logic [hdr_tm_pkg::PV_W-1:0] num_s5, den_s5;

	// Exposure: shift by the integer stop count with rounding, then saturate.
	logic [6:0]    s7;
	logic [5:0]    sh;
	logic [PW+1:0] esum, eshift;

	assign s7 = 7'(7'sd22 - $signed({{2{exp_int[4]}}, exp_int}));
	assign sh = s7[5:0];
	assign esum = (PW+2)'(prod_s1) + ((PW+2)'(1) << (sh - 6'd1));
	assign eshift = esum >> sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(x) * PW'(gain);
			e_s2 <= (eshift > (PW+2)'(hdr_tm_pkg::E_MAX)) ? hdr_tm_pkg::E_MAX :
				hdr_tm_pkg::E_W'(eshift);
		end
	end

	logic [hdr_tm_pkg::WP_W-1:0] w;
	logic [hdr_tm_pkg::E_W:0]    rd;
	logic [NW-1:0]               a_num;
	logic [DW-1:0]               a_den;
	logic                        a_vld, a_ovf;
	logic [hdr_tm_pkg::DIV_Q_W-1:0] a_quo;

	assign w = (white_point == '0) ? hdr_tm_pkg::WP_W'(1) : white_point;
	assign rd = {1'b0, e_s2} + (hdr_tm_pkg::E_W+1)'(hdr_tm_pkg::T_ONE);
	assign a_num = tone_curve ? ((NW'(1) << 48) + NW'(rd >> 1)) :
		({16'd0, e_s2, 8'd0} + NW'(w >> 1));
	assign a_den = tone_curve ? DW'(rd) : DW'(w);

	hdr_tm_div u_div_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s2),
		.num     (a_num),
		.den     (a_den),
		.vld_out (a_vld),
		.quo     (a_quo),
		.ovf     (a_ovf)
	);

	logic [hdr_tm_pkg::T_W-1:0] rt;
	logic [54:0] pa, pb;
	logic [58:0] pn, pd;

	assign rt = hdr_tm_pkg::T_ONE - hdr_tm_pkg::T_W'(a_quo);
	assign pa = 55'(hdr_tm_pkg::ACES_A1) * 55'(c_s3) + (55'd1 << 23);
	assign pb = 55'(hdr_tm_pkg::ACES_A2) * 55'(c_s3) + (55'd1 << 23);
	assign pn = 59'(c_s4) * 59'(ma_s4) + (59'd1 << 23);
	assign pd = 59'(c_s4) * 59'(mb_s4) + (59'd1 << 23);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s3 <= a_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (tone_curve) begin
				c_s3 <= hdr_tm_pkg::C_W'(rt);
			end else begin
				c_s3 <= (a_ovf || a_quo > hdr_tm_pkg::DIV_Q_W'(hdr_tm_pkg::C_MAX)) ?
					hdr_tm_pkg::C_MAX : hdr_tm_pkg::C_W'(a_quo);
			end
			ma_s4 <= hdr_tm_pkg::MA_W'(pa >> 24) + hdr_tm_pkg::ACES_B1;
			mb_s4 <= hdr_tm_pkg::MA_W'(pb >> 24) + hdr_tm_pkg::ACES_B2;
			c_s4 <= c_s3;
			num_s5 <= hdr_tm_pkg::PV_W'(pn >> 24);
			den_s5 <= hdr_tm_pkg::PV_W'(pd >> 24) + hdr_tm_pkg::ACES_D0;
			c_s5 <= c_s4;
		end
	end

	logic [NW-1:0] b_num;
	logic [DW-1:0] b_den;
	logic          b_vld, b_ovf;
	logic [hdr_tm_pkg::DIV_Q_W-1:0] b_quo;
	logic [hdr_tm_pkg::T_W-1:0]     tval;

	// The Reinhard result already sits in c and passes through a divide by one.
	assign b_num = tone_curve ? NW'(c_s5) :
		({5'd0, num_s5, 24'd0} + NW'(den_s5 >> 1));
	assign b_den = tone_curve ? DW'(1) : DW'(den_s5);

	hdr_tm_div u_div_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_s5),
		.num     (b_num),
		.den     (b_den),
		.vld_out (b_vld),
		.quo     (b_quo),
		.ovf     (b_ovf)
	);

	assign tval = (b_ovf || b_quo > hdr_tm_pkg::DIV_Q_W'(hdr_tm_pkg::T_ONE)) ?
		hdr_tm_pkg::T_ONE : hdr_tm_pkg::T_W'(b_quo);

	hdr_tm_enc u_enc (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (b_vld),
		.t       (tval),
		.vld_out (vld_out),
		.code    (code)
	);

endmodule

/* sv/hdr_tone_map_srgb_encode.sv */
// Throughput: one pixel per cycle while s_axis_tready is high; the three channels run in parallel lanes.
// The lane depth is set by two 30-step pipelined dividers and two 16-step log and exp chains.
// After reset, and after each write of exposure_stops, s_axis_tready stays low
// while the exposure gain pipeline settles. Reset loads the register defaults.
module hdr_tone_map_srgb_encode (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// red_hdr [23:0], green_hdr [47:24], blue_hdr [71:48]
	input  logic [hdr_tm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// red_srgb [11:0], green_srgb [23:12], blue_srgb [35:24], zero fill above
	output logic [hdr_tm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [hdr_tm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hdr_tm_pkg::WP_W-1:0]            cfg_data
);

	localparam int CH = hdr_tm_pkg::CH;
	localparam int OW = hdr_tm_pkg::OUT_W;

	logic [hdr_tm_pkg::EXP_W-1:0]    exposure_q;
	logic                            tone_q;
	logic [hdr_tm_pkg::WP_W-1:0]     white_q;
	logic [hdr_tm_pkg::SETTLE_W-1:0] settle_q;
	logic [hdr_tm_pkg::G_W-1:0]      gain;

	logic                            adv;
	logic                            in_xfer;
	logic [CH-1:0]                   lane_vld;
	logic [CH*OW-1:0]                lane_data;
	logic                            out_valid_q, skid_valid_q;
	logic [CH*OW-1:0]                out_data_q, skid_data_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exposure_q <= '0;
			tone_q <= 1'b0;
			white_q <= hdr_tm_pkg::WP_RESET;
			settle_q <= hdr_tm_pkg::SETTLE_W'(hdr_tm_pkg::GAIN_STAGES);
		end else begin
			if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (hdr_tm_pkg::cfg_index_t'(cfg_index))
					hdr_tm_pkg::CFG_EXPOSURE: begin
						exposure_q <= cfg_data[hdr_tm_pkg::EXP_W-1:0];
						settle_q <= hdr_tm_pkg::SETTLE_W'(hdr_tm_pkg::GAIN_STAGES);
					end
					hdr_tm_pkg::CFG_TONE: begin
						tone_q <= cfg_data[0];
					end
					hdr_tm_pkg::CFG_WHITE: begin
						white_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	hdr_tm_gain u_gain (
		.clk  (clk),
		.frac (exposure_q[hdr_tm_pkg::GAIN_STAGES-1:0]),
		.gain (gain)
	);

	assign adv = !skid_valid_q;
	assign s_axis_tready = adv && (settle_q == '0);
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	for (genvar i = 0; i < CH; i++) begin : g_lane
		hdr_tm_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (adv),
			.vld_in      (in_xfer),
			.x           (s_axis_tdata[i*hdr_tm_pkg::IN_W +: hdr_tm_pkg::IN_W]),
			.gain        (gain),
			.exp_int     (exposure_q[hdr_tm_pkg::EXP_W-1:hdr_tm_pkg::GAIN_STAGES]),
			.tone_curve  (tone_q),
			.white_point (white_q),
			.vld_out     (lane_vld[i]),
			.code        (lane_data[i*OW +: OW])
		);
	end

	// Merge the lanes into one output word, with a skid slot behind the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || m_axis_tready) begin
				if (skid_valid_q) begin
					out_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= lane_vld[0];
				end
			end else if (lane_vld[0] && adv) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : lane_data;
		end else if (adv) begin
			skid_data_q <= lane_data;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = hdr_tm_pkg::OUT_TDATA_W'(out_data_q);

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(lane_vld) == 0 || $countones(lane_vld) == CH)
		else $error("lane valid bits disagree");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("skid slot filled while output was free");

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot holds data while output register is empty");

	a_settle_block: assert property (@(posedge clk) disable iff (!arst_n)
		settle_q != '0 |-> !s_axis_tready)
		else $error("input ready while gain pipeline settles");

endmodule

/* bench/tb_hdr_tone_map_srgb_encode.sv */
module tb_hdr_tone_map_srgb_encode;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W = hdr_tm_pkg::IN_W;
	localparam int OUT_W = hdr_tm_pkg::OUT_W;
	localparam int EXP_W = hdr_tm_pkg::EXP_W;
	localparam int WP_W = hdr_tm_pkg::WP_W;
	localparam int IN_TDATA_W = hdr_tm_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = hdr_tm_pkg::OUT_TDATA_W;
	localparam int LATENCY = 105;
	localparam logic [63:0] OUT_M = (64'd1 << OUT_W) - 1;

	typedef struct packed {
		logic [IN_W-1:0] blue;
		logic [IN_W-1:0] green;
		logic [IN_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [OUT_W-1:0] blue;
		logic [OUT_W-1:0] green;
		logic [OUT_W-1:0] red;
	} code_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	hdr_tm_pkg::cfg_index_t cfg_index = hdr_tm_pkg::CFG_EXPOSURE;
	logic [WP_W-1:0] cfg_data = '0;

	pixel_t pending_pixels[$];
	code_t expected_codes[$];
	int errors = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;
	logic stall_enable = 1'b1;

	logic [EXP_W-1:0] exposure_reg;
	logic tone_reg;
	logic [WP_W-1:0] white_reg;

	hdr_tone_map_srgb_encode i_dut (.*);

	always #5 clk = ~clk;

	function automatic logic [63:0] frac_pow2(input logic [31:0] u, input int nbits);
		logic [63:0] g;
		g = 64'd1 << 30;
		for (int i = 0; i < nbits; i++)
			if (u[nbits-1-i])
				g = (g * 64'(hdr_tm_pkg::POW2_TAB[i]) + (64'd1 << 29)) >> 30;
		return g;
	endfunction

	function automatic logic [63:0] tone_curve_out(input logic [63:0] x);
		int shift_n;
		logic [63:0] prod, e, t, d, w, c, num, den;
		shift_n = 22 - $signed({{19{exposure_reg[EXP_W-1]}}, exposure_reg[EXP_W-1:8]});
		prod = x * frac_pow2({24'd0, exposure_reg[7:0]}, 8);
		e = (prod + (64'd1 << (shift_n - 1))) >> shift_n;
		if (e > 64'(hdr_tm_pkg::E_MAX))
			e = 64'(hdr_tm_pkg::E_MAX);
		if (tone_reg) begin
			d = e + (64'd1 << 24);
			t = (64'd1 << 24) - (((64'd1 << 48) + d / 2) / d);
		end else begin
			w = (white_reg != 0) ? 64'(white_reg) : 64'd1;
			c = ((e << 8) + w / 2) / w;
			if (c > (64'd1 << 28))
				c = 64'd1 << 28;
			num = (c * (((64'd42110730 * c + (64'd1 << 23)) >> 24) + 64'd503316)
				+ (64'd1 << 23)) >> 24;
			den = ((c * (((64'd40768532 * c + (64'd1 << 23)) >> 24) + 64'd9898557)
				+ (64'd1 << 23)) >> 24) + 64'd2348810;
			t = ((num << 24) + den / 2) / den;
			if (t > (64'd1 << 24))
				t = 64'd1 << 24;
		end
		return t;
	endfunction

	function automatic logic [OUT_W-1:0] srgb_code(input logic [63:0] t);
		int p;
		logic [63:0] r, man, p30, sv;
		logic [31:0] frac, nl, ny, k, f;
		if (t <= 64'd52526) begin
			r = (t * 64'd846725 * OUT_M + (64'd1 << 39)) >> 40;
		end else begin
			p = 24;
			while (p > 0 && !t[p])
				p--;
			man = t << (30 - p);
			frac = 0;
			for (int i = 0; i < 16; i++) begin
				man = (man * man + (64'd1 << 29)) >> 30;
				frac = frac << 1;
				if (man >= (64'd1 << 31)) begin
					frac = frac | 1;
					man = man >> 1;
				end
			end
			nl = (32'(24 - p) << 16) - frac;
			ny = (nl * 5 + 6) / 12;
			k = ny >> 16;
			f = ny & 32'hFFFF;
			if (f == 0)
				p30 = (64'd1 << 30) >> k;
			else
				p30 = frac_pow2(32'd65536 - f, 16) >> (k + 1);
			sv = (p30 * 64'd69140 + (64'd1 << 15)) >> 16;
			sv = (sv > 64'd59055800) ? sv - 64'd59055800 : 64'd0;
			r = (sv * OUT_M + (64'd1 << 29)) >> 30;
		end
		return (r > OUT_M) ? OUT_W'(OUT_M) : OUT_W'(r);
	endfunction

	function automatic code_t encode_pixel(input pixel_t px);
		code_t c;
		c.red = srgb_code(tone_curve_out(64'(px.red)));
		c.green = srgb_code(tone_curve_out(64'(px.green)));
		c.blue = srgb_code(tone_curve_out(64'(px.blue)));
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			expected_codes.push_back(encode_pixel(pixel_t'(s_axis_tdata)));
			void'(pending_pixels.pop_front());
		end
		if (s_axis_tvalid && !s_axis_tready) begin
			s_axis_tvalid <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			s_axis_tvalid <= 1'b0;
		end else if (pending_pixels.size() > 0 && burst_left > 0) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= IN_TDATA_W'(pending_pixels[0]);
			burst_left <= burst_left - 1;
		end else begin
			s_axis_tvalid <= 1'b0;
			if (burst_left <= 0) begin
				burst_left <= $urandom_range(1, 40);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end
		end
	end

	always @(posedge clk) begin
		stall_phase <= (stall_phase + 1) % 97;
		m_axis_tready <= !stall_enable || stall_phase < 40 || (stall_phase % 7) < 3;
		if (m_axis_tvalid && m_axis_tready) begin
			code_t got, want;
			got = code_t'(m_axis_tdata[3*OUT_W-1:0]);
			if (m_axis_tdata[OUT_TDATA_W-1:3*OUT_W] != 0)
				report_mismatch("nonzero fill bits in result");
			if (expected_codes.size() == 0) begin
				report_mismatch("result with none expected");
			end else begin
				want = expected_codes.pop_front();
				if (got.red != want.red)
					report_mismatch($sformatf("red %0d want %0d", got.red, want.red));
				if (got.green != want.green)
					report_mismatch($sformatf("green %0d want %0d", got.green, want.green));
				if (got.blue != want.blue)
					report_mismatch($sformatf("blue %0d want %0d", got.blue, want.blue));
			end
		end
	end

	task automatic write_reg(input hdr_tm_pkg::cfg_index_t idx, input logic [WP_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			hdr_tm_pkg::CFG_EXPOSURE: exposure_reg = value[EXP_W-1:0];
			hdr_tm_pkg::CFG_TONE: tone_reg = value[0];
			default: white_reg = value;
		endcase
	endtask

	task automatic drain;
		while (pending_pixels.size() != 0 || expected_codes.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	function automatic logic [IN_W-1:0] rand_channel;
		case ($urandom_range(0, 4))
			0: return IN_W'($urandom_range(0, 255));
			1: return IN_W'($urandom_range(0, 32'h1FFFF));
			2: return IN_W'(32'h10000 >> $urandom_range(0, 16));
			default: return IN_W'($urandom);
		endcase
	endfunction

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			pending_pixels.push_back({rand_channel(), rand_channel(), rand_channel()});
	endtask

	initial begin
		logic [IN_W-1:0] edges[6] = '{24'd0, 24'd1, 24'd205, 24'h10000, 24'h7FFFFF, 24'hFFFFFF};
		exposure_reg = '0;
		tone_reg = 1'b0;
		white_reg = hdr_tm_pkg::WP_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < 6; i++)
			pending_pixels.push_back({edges[(i + 2) % 6], edges[(i + 1) % 6], edges[i]});
		pending_pixels.push_back({24'h5555AA, 24'hAAAA55, 24'h0C8000});
		drain();
		write_reg(hdr_tm_pkg::CFG_TONE, 16'hFFFF);
		for (int i = 0; i < 6; i++)
			pending_pixels.push_back({edges[i], edges[(i + 3) % 6], edges[(i + 5) % 6]});
		drain();
		write_reg(hdr_tm_pkg::CFG_TONE, 16'h0000);
		write_reg(hdr_tm_pkg::CFG_WHITE, 16'd0);
		write_reg(hdr_tm_pkg::CFG_EXPOSURE, 16'h0FFF);
		for (int i = 0; i < 6; i++)
			pending_pixels.push_back({edges[i], edges[i], edges[i]});
		drain();
		write_reg(hdr_tm_pkg::CFG_EXPOSURE, 16'h1000);
		write_reg(hdr_tm_pkg::CFG_WHITE, 16'hFFFF);
		for (int i = 0; i < 6; i++)
			pending_pixels.push_back({edges[i], edges[(i + 4) % 6], edges[i]});
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			stall_enable = (ph % 3) != 2;
			write_reg(hdr_tm_pkg::CFG_EXPOSURE, 16'($urandom_range(0, 8191)) & 16'h1FFF);
			write_reg(hdr_tm_pkg::CFG_TONE, 16'($urandom));
			write_reg(hdr_tm_pkg::CFG_WHITE, ($urandom_range(0, 3) == 0)
				? 16'($urandom) : 16'($urandom_range(64, 1024)));
			if (ph % 2 == 0)
				write_reg(hdr_tm_pkg::CFG_EXPOSURE,
					16'($urandom_range(3072, 5120)) & 16'h1FFF);
			queue_random(100);
			drain();
		end
		if (errors == 0)
			$display("[hdr_tone_map_srgb_encode] OK");
		else
			$display("[hdr_tone_map_srgb_encode] ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("[hdr_tone_map_srgb_encode] ERROR");
		$finish;
	end
endmodule
